/* sv/bfsa_pkg.sv */
`timescale 1ns / 1ps
package bfsa_pkg;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BLOCKS  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam int SIZE_W = 29;
  localparam int END_W  = 30;
  localparam int ALIGN_W = 17;
  localparam int BLK_W = 4;
  localparam int VAL_W = 31;
  // new block sizes are rounded up to a multiple of this power of two
  localparam int BLOCK_ALIGN = 4096;

  // start is as wide as stop: merged or split spans can begin past 2^29
  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [END_W-1:0]  start;
    logic [END_W-1:0]  stop;
  } span_t;

  // candidate evaluation result from the shared compare unit
  typedef struct packed {
    logic              fits;
    logic [VAL_W-1:0]  al;
    logic [VAL_W-1:0]  waste;
    logic              adj_lo;
    logic              adj_hi;
  } eval_t;
endpackage

/* sv/best_fit_span_allocator_unit.sv */
`timescale 1ns / 1ps
// Best-fit free-span allocator. A request is taken when start is high and busy
// is low; one result comes back on done for a single cycle and cannot be
// stalled. A request on a non-empty table scans the span table one entry per
// cycle through one shared evaluation unit; when a span is reused or freed it
// then rewrites the table with a read state and a write state per entry, since
// the table read data is registered. A free of an unknown block skips the scan.
// busy drops in the cycle done is high, so the next request can be taken at
// the edge that ends that cycle.
module best_fit_span_allocator_unit #(
  parameter int MAX_SPANS   = 64,
  parameter int MAX_BLOCKS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [28:0] size,
  input  logic [16:0] align,
  input  logic [3:0]  free_block,
  input  logic [28:0] free_offset,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  block_index,
  output logic [28:0] offset,
  output logic        opened_block,
  output logic [29:0] opened_size
);
  localparam int IW = $clog2(MAX_SPANS);
  localparam int CW = $clog2(MAX_SPANS + 1);
  localparam int BW = $clog2(MAX_BLOCKS + 1);
  localparam int VW = bfsa_pkg::VAL_W;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_SCAN = 4'd2, S_DEC = 4'd3,
    S_MV_RD = 4'd4, S_MV_WR = 4'd5, S_APP1 = 4'd6, S_APP2 = 4'd7, S_DONE = 4'd8,
    S_OPEN = 4'd9, S_OPEN2 = 4'd10;

  logic [3:0] state;
  bfsa_pkg::span_t mem [MAX_SPANS];
  bfsa_pkg::span_t rdata;
  logic [IW-1:0] raddr;
  logic wen;
  logic [IW-1:0] waddr;
  bfsa_pkg::span_t wdata;

  logic [28:0] dflt;
  logic [CW-1:0] span_count, idx, wptr;
  logic [BW-1:0] block_count;
  logic rq;
  logic [28:0] rsize;
  logic [16:0] ralign;
  logic [3:0] rblk;
  logic [VW-1:0] fs, fe;
  logic found;
  logic [IW-1:0] best;
  logic [VW-1:0] best_al, best_waste;
  bfsa_pkg::span_t best_span;
  logic [VW-1:0] bsize;
  bfsa_pkg::eval_t ev;
  logic [MAX_SPANS-1:0] keep;
  logic lead, trail;
  logic [VW-1:0] aend;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  bfsa_eval u_eval (
    .span(rdata), .size(rsize), .align(ralign), .fblk(rblk), .fs(fs), .fe(fe), .res(ev)
  );

  assign pready = 1'b1;
  assign prdata = {3'd0, dflt};
  assign busy = (state != S_IDLE);

  always_comb begin
    aend = best_al + VW'(rsize);
    lead = best_al > VW'(best_span.start);
    trail = aend < VW'(best_span.stop);
  end

  logic [VW:0] want, want_max, rounded;
  always_comb begin
    want = (VW+1)'(rsize) + (VW+1)'(ralign);
    want_max = ((VW+1)'(dflt) > want) ? (VW+1)'(dflt) : want;
    rounded = (want_max + (VW+1)'(bfsa_pkg::BLOCK_ALIGN - 1))
              & ~((VW+1)'(bfsa_pkg::BLOCK_ALIGN - 1));
  end

  always_ff @(posedge clk) begin
    wen <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      span_count <= '0;
      block_count <= '0;
      dflt <= 29'd1048576;
      idx <= '0;
      raddr <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == 1'b0) dflt <= pwdata[28:0];
      unique case (state)
        S_IDLE: if (start) begin
          rq <= req_type; rsize <= size; ralign <= align; rblk <= free_block;
          fs <= VW'(free_offset);
          fe <= VW'(free_offset) + VW'(size);
          found <= 1'b0;
          best_waste <= '1;
          idx <= '0;
          raddr <= '0;
          status <= bfsa_pkg::ST_OK; block_index <= '0; offset <= '0;
          opened_block <= 1'b0; opened_size <= '0;
          keep <= '0;
          if (req_type == bfsa_pkg::REQ_FREE &&
              {{BW{1'b0}}, free_block} >= {4'd0, block_count}) begin
            status <= bfsa_pkg::ST_UNKNOWN;
            state <= S_DONE;
          end else if (span_count == '0) state <= S_DEC;
          else state <= S_RD;
        end
        S_RD: begin
          raddr <= IW'(idx + 1'b1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rq == bfsa_pkg::REQ_ALLOC) begin
            if (ev.fits && ev.waste < best_waste) begin
              found <= 1'b1; best <= IW'(idx); best_al <= ev.al;
              best_waste <= ev.waste; best_span <= rdata;
            end
          end else begin
            // merge order matters: later adjacencies see the grown region
            if (ev.adj_lo) fs <= VW'(rdata.start);
            else if (ev.adj_hi) fe <= VW'(rdata.stop);
            else keep[IW'(idx)] <= 1'b1;
          end
          raddr <= IW'(idx + 2'd2);
          idx <= idx + 1'b1;
          if (idx + 1'b1 == span_count) state <= S_DEC;
        end
        S_DEC: begin
          idx <= '0; wptr <= '0; raddr <= '0;
          if (rq == bfsa_pkg::REQ_ALLOC) begin
            if (found) begin
              if ((span_count - 1'b1 + CW'(lead) + CW'(trail)) > CW'(MAX_SPANS)) begin
                status <= bfsa_pkg::ST_FULL; state <= S_DONE;
              end else begin
                block_index <= best_span.blk; offset <= best_al[28:0];
                keep <= ~({{(MAX_SPANS-1){1'b0}}, 1'b1} << best);
                state <= S_MV_RD;
              end
            end else state <= S_OPEN;
          end else if (span_count == CW'(MAX_SPANS) && &keep) begin
            // full table and nothing merged: no room for the freed span
            status <= bfsa_pkg::ST_FULL; state <= S_DONE;
          end else begin
            state <= (span_count == '0) ? S_APP1 : S_MV_RD;
          end
        end
        S_OPEN: begin
          bsize <= rounded[VW-1:0];
          state <= S_OPEN2;
        end
        S_OPEN2: begin
          if (block_count >= BW'(MAX_BLOCKS)) begin
            status <= bfsa_pkg::ST_BLOCKS; state <= S_DONE;
          end else if (VW'(rsize) < bsize && span_count >= CW'(MAX_SPANS)) begin
            status <= bfsa_pkg::ST_FULL; state <= S_DONE;
          end else begin
            block_index <= 4'(block_count); offset <= '0;
            opened_block <= 1'b1; opened_size <= bsize[29:0];
            block_count <= block_count + 1'b1;
            if (VW'(rsize) < bsize) begin
              wen <= 1'b1; waddr <= IW'(span_count);
              wdata <= '{blk: 4'(block_count), start: bfsa_pkg::END_W'(rsize),
                         stop: bsize[29:0]};
              span_count <= span_count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: begin
          // compaction: read at idx, write kept entries at wptr
          if (keep[IW'(idx)]) begin
            wen <= 1'b1; waddr <= IW'(wptr); wdata <= rdata;
            wptr <= wptr + 1'b1;
          end
          if (idx + 1'b1 == span_count) begin
            state <= S_APP1;
          end else begin
            raddr <= IW'(idx + 1'b1);
            idx <= idx + 1'b1;
            state <= S_MV_RD;
          end
        end
        S_APP1: begin
          if (rq == bfsa_pkg::REQ_FREE) begin
            wen <= 1'b1; waddr <= IW'(wptr);
            wdata <= '{blk: rblk, start: fs[29:0], stop: fe[29:0]};
            span_count <= wptr + 1'b1;
            state <= S_DONE;
          end else begin
            if (lead) begin
              wen <= 1'b1; waddr <= IW'(wptr);
              wdata <= '{blk: best_span.blk, start: best_span.start, stop: best_al[29:0]};
              wptr <= wptr + 1'b1;
            end
            state <= S_APP2;
          end
        end
        S_APP2: begin
          if (trail) begin
            wen <= 1'b1; waddr <= IW'(wptr);
            wdata <= '{blk: best_span.blk, start: aend[29:0], stop: best_span.stop};
          end
          span_count <= wptr + CW'(trail);
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    span_count <= CW'(MAX_SPANS)) else $error("span count overflow");
  a_blocks_bound: assert property (@(posedge clk) disable iff (rst)
    block_count <= BW'(MAX_BLOCKS)) else $error("block count overflow");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_open_ok: assert property (@(posedge clk) disable iff (rst)
    done && opened_block |-> status == bfsa_pkg::ST_OK) else $error("open with error");
`endif
endmodule

/* sv/bfsa_eval.sv */
`timescale 1ns / 1ps
// Shared per-entry unit: align-up, fit test, waste, and adjacency for free.
module bfsa_eval (
  input  bfsa_pkg::span_t                 span,
  input  logic [bfsa_pkg::SIZE_W-1:0]     size,
  input  logic [bfsa_pkg::ALIGN_W-1:0]    align,
  input  logic [bfsa_pkg::BLK_W-1:0]      fblk,
  input  logic [bfsa_pkg::VAL_W-1:0]      fs,
  input  logic [bfsa_pkg::VAL_W-1:0]      fe,
  output bfsa_pkg::eval_t                 res
);
  logic [bfsa_pkg::ALIGN_W-1:0] am;
  logic [bfsa_pkg::VAL_W-1:0] sum, ext_end, ext_start;
  logic [bfsa_pkg::VAL_W:0] aend;

  always_comb begin
    am = (align == '0) ? '0 : align - 1'b1;
    ext_start = bfsa_pkg::VAL_W'(span.start);
    ext_end = bfsa_pkg::VAL_W'(span.stop);
    sum = ext_start + bfsa_pkg::VAL_W'(am);
    res.al = sum & ~bfsa_pkg::VAL_W'(am);
    aend = {1'b0, res.al} + (bfsa_pkg::VAL_W+1)'(size);
    res.fits = aend <= {1'b0, ext_end};
    res.waste = ext_end - ext_start - bfsa_pkg::VAL_W'(size);
    res.adj_lo = (span.blk == fblk) && (ext_end == fs);
    res.adj_hi = (span.blk == fblk) && (ext_start == fe);
  end
endmodule
